// ===== design/bmhq_pkg.sv =====
// Package for the binary max-heap queue: item types, codes and sizes.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

	localparam int HEAP_CAPACITY = 512;
	localparam int KEY_W         = 16;
	localparam int COUNT_W       = 10;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] score;
		logic [KEY_W-1:0] tag;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]   popped_score;
		logic [KEY_W-1:0]   popped_tag;
		logic [KEY_W-1:0]   top_score;
		logic [KEY_W-1:0]   top_tag;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] score;
		logic [KEY_W-1:0] tag;
	} entry_t;

	localparam int ENTRY_W = 2 * KEY_W;

endpackage
`default_nettype wire

// ===== design/binary_max_heap_queue_top.sv =====
// Binary max-heap priority queue: sequencer, heap RAM and output register.
// An insert climbs the heap level by level and a pop descends it level by level, every step
// going through the single registered RAM read port feeding one comparator. One item at a
// time; a result may wait in the output register while the next item runs. Reset clears
// count, not RAM.
`timescale 1ns / 1ps
`default_nettype none
module binary_max_heap_queue_top
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = HEAP_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire in_item_t  req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output out_item_t      rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic          res_valid;
	logic          res_ready;
	logic          res_take;
	out_item_t     res;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;
	logic          rsp_valid_q;
	out_item_t     rsp_q;

	bmhq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bmhq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Load the output register when it is free or being drained
	assign res_ready = !rsp_valid_q || !rsp_stall;
	assign res_take  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An accepted item holds off the next one: the input stalls in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input taken on back-to-back cycles");

	// A finished item shows up at the output the next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> rsp_valid)
		else $error("finished item not presented");

	// Refused items carry no popped pair
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.popped_score == '0 && rsp.popped_tag == '0)
		else $error("refused item reports a popped pair");

	// An empty-pop refusal sees an empty heap
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.top_score == '0)
		else $error("empty refusal with entries held");

endmodule
`default_nettype wire

// ===== design/bmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/bmhq_ctrl.sv =====
// Heap sequencer: sift-up and sift-down over the heap RAM with one shared comparator.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ctrl
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = HEAP_CAPACITY
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire in_item_t                    req,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output out_item_t                        res,
	output logic                             ram_we,
	output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
	output entry_t                           ram_wdata,
	output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
	input  wire entry_t                      ram_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_UP, S_UPCMP, S_POPRD, S_POPLAST, S_DN, S_DNL, S_DNR, S_DNCMP,
		S_TOPRD, S_TOPWAIT, S_DONE
	} state_t;

	state_t           state_q;
	logic [SW-1:0]    cnt_q;
	logic [SW-1:0]    pos_q;
	logic [SW-1:0]    child_pos_q;
	entry_t           cur_q;
	entry_t           child_q;
	entry_t           popped_q;
	entry_t           top_q;
	status_t          status_q;

	logic [SW:0]      left_slot;
	logic [SW-1:0]    right_slot;
	logic [SW-1:0]    parent_slot;
	logic             left_past_end;
	logic             right_exists;
	logic [KEY_W-1:0] cmp_a;
	logic [KEY_W-1:0] cmp_b;
	logic             gt;

	// Map a heap slot (from one) to a RAM address (from zero)
	function automatic logic [AW-1:0] to_addr(input logic [SW-1:0] slot);
		logic [SW-1:0] d;
		d = slot - 1'b1;
		return d[AW-1:0];
	endfunction

	// Neighbor slots of the current position
	assign left_slot     = {pos_q, 1'b0};
	assign right_slot    = left_slot[SW-1:0] + 1'b1;
	assign parent_slot   = pos_q >> 1;
	assign left_past_end = left_slot > {1'b0, cnt_q};
	assign right_exists  = left_slot < {1'b0, cnt_q};

	// Steer the shared score comparator
	always_comb begin
		cmp_a = cur_q.score;
		cmp_b = ram_rdata.score;
		unique case (state_q)
			S_DNR: begin
				cmp_a = ram_rdata.score;
				cmp_b = child_q.score;
			end
			S_DNCMP: begin
				cmp_a = child_q.score;
				cmp_b = cur_q.score;
			end
			default: begin
				cmp_a = cur_q.score;
				cmp_b = ram_rdata.score;
			end
		endcase
	end
	assign gt = cmp_a > cmp_b;

	// Drive RAM ports from the current state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = to_addr(pos_q);
		ram_wdata = cur_q;
		ram_raddr = to_addr(SW'(1));
		unique case (state_q)
			S_UP: begin
				if (pos_q == SW'(1)) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = to_addr(parent_slot);
				end
			end
			S_UPCMP: begin
				ram_we = 1'b1;
				if (gt) begin
					ram_wdata = ram_rdata;
				end
			end
			S_POPRD: begin
				ram_raddr = to_addr(cnt_q);
			end
			S_DN: begin
				if (left_past_end) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = to_addr(left_slot[SW-1:0]);
				end
			end
			S_DNL: begin
				ram_raddr = to_addr(right_slot);
			end
			S_DNCMP: begin
				ram_we = 1'b1;
				if (gt) begin
					ram_wdata = child_q;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequence one item through the heap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			child_pos_q <= '0;
			cur_q       <= '0;
			child_q     <= '0;
			popped_q    <= '0;
			top_q       <= '0;
			status_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						popped_q <= '0;
						status_q <= ST_OK;
						if (req.action == ACT_INSERT) begin
							if (cnt_q == SW'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_TOPRD;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								pos_q   <= cnt_q + 1'b1;
								cur_q   <= '{score: req.score, tag: req.tag};
								state_q <= S_UP;
							end
						end else if (cnt_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_TOPRD;
						end else begin
							state_q <= S_POPRD;
						end
					end
				end
				S_UP: begin
					state_q <= (pos_q == SW'(1)) ? S_TOPRD : S_UPCMP;
				end
				S_UPCMP: begin
					if (gt) begin
						pos_q   <= parent_slot;
						state_q <= S_UP;
					end else begin
						state_q <= S_TOPRD;
					end
				end
				S_POPRD: begin
					popped_q <= ram_rdata;
					state_q  <= S_POPLAST;
				end
				S_POPLAST: begin
					cur_q   <= ram_rdata;
					cnt_q   <= cnt_q - 1'b1;
					pos_q   <= SW'(1);
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= left_past_end ? S_TOPRD : S_DNL;
				end
				S_DNL: begin
					child_q     <= ram_rdata;
					child_pos_q <= left_slot[SW-1:0];
					state_q     <= right_exists ? S_DNR : S_DNCMP;
				end
				S_DNR: begin
					// Right child wins only when strictly larger
					if (gt) begin
						child_q     <= ram_rdata;
						child_pos_q <= right_slot;
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (gt) begin
						pos_q   <= child_pos_q;
						state_q <= S_DN;
					end else begin
						state_q <= S_TOPRD;
					end
				end
				S_TOPRD: begin
					state_q <= S_TOPWAIT;
				end
				S_TOPWAIT: begin
					top_q   <= (cnt_q != '0) ? ram_rdata : '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Present the finished item
	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res = '{
		popped_score: popped_q.score,
		popped_tag:   popped_q.tag,
		top_score:    top_q.score,
		top_tag:      top_q.tag,
		count:        COUNT_W'(cnt_q),
		status:       status_q
	};

endmodule
`default_nettype wire

// ===== tb/tb_binary_max_heap_queue_top.sv =====
// Self-checking testbench for the binary max-heap queue: random and directed inserts and pops.
`timescale 1ns / 1ps
module tb_binary_max_heap_queue_top
	import bmhq_pkg::*;
();

	// Receiver stall styles, switched at random stretches
	typedef enum logic [1:0] {
		RX_OPEN  = 2'd0,
		RX_LIGHT = 2'd1,
		RX_HEAVY = 2'd2,
		RX_COMB  = 2'd3
	} rx_style_t;

	typedef struct {
		in_item_t item;
		bit       drain_first;
	} pending_t;

	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER  = 150;
	localparam int MAX_REPORTS = 40;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	// Shadow heap: slots 1..HEAP_CAPACITY, as in the block
	entry_t      heap_mem [1:HEAP_CAPACITY];
	int unsigned heap_fill = 0;
	int unsigned heap_peak = 0;

	pending_t  pending_q [$];
	out_item_t replies_due [$];

	bit          req_taken    = 1'b0;
	int unsigned fail_count   = 0;
	int unsigned items_taken  = 0;
	int unsigned replies_seen = 0;
	int unsigned n_insert     = 0;
	int unsigned n_pop        = 0;
	int unsigned n_full       = 0;
	int unsigned n_empty      = 0;

	int        burst_left = 1;
	int        gap_left   = 0;
	int        hold_left  = 0;
	bit        hold_done  = 1'b0;
	int        style_left = 0;
	int        comb_phase = 0;
	rx_style_t rx_style   = RX_OPEN;

	binary_max_heap_queue_top #(
		.CAPACITY(HEAP_CAPACITY)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Apply one item to the shadow heap and return the reply it should produce
	function automatic out_item_t heap_apply(input in_item_t it);
		out_item_t   r;
		entry_t      t;
		int unsigned pos;
		int unsigned kid;
		r = '0;
		r.status = ST_OK;
		if (it.action == ACT_INSERT) begin
			n_insert++;
			if (heap_fill >= HEAP_CAPACITY) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				heap_fill++;
				heap_mem[heap_fill].score = it.score;
				heap_mem[heap_fill].tag   = it.tag;
				pos = heap_fill;
				// climb while strictly greater than the parent
				while (pos > 1 && heap_mem[pos].score > heap_mem[pos / 2].score) begin
					t = heap_mem[pos];
					heap_mem[pos] = heap_mem[pos / 2];
					heap_mem[pos / 2] = t;
					pos = pos / 2;
				end
			end
		end else begin
			n_pop++;
			if (heap_fill == 0) begin
				r.status = ST_EMPTY;
				n_empty++;
			end else begin
				r.popped_score = heap_mem[1].score;
				r.popped_tag   = heap_mem[1].tag;
				heap_mem[1] = heap_mem[heap_fill];
				heap_fill--;
				pos = 1;
				// sink toward the larger child; right wins only when strictly larger
				while (2 * pos <= heap_fill) begin
					kid = 2 * pos;
					if (kid < heap_fill && heap_mem[kid + 1].score > heap_mem[kid].score)
						kid++;
					if (heap_mem[kid].score > heap_mem[pos].score) begin
						t = heap_mem[kid];
						heap_mem[kid] = heap_mem[pos];
						heap_mem[pos] = t;
						pos = kid;
					end else begin
						break;
					end
				end
			end
		end
		if (heap_fill > heap_peak)
			heap_peak = heap_fill;
		if (heap_fill != 0) begin
			r.top_score = heap_mem[1].score;
			r.top_tag   = heap_mem[1].tag;
		end
		r.count = heap_fill[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	// Keys: ties from a narrow range, the extremes, or anything
	function automatic logic [KEY_W-1:0] pick_score();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		if (sel < 4)
			return KEY_W'($urandom_range(0, 7));
		if (sel == 4)
			return '0;
		if (sel == 5)
			return '1;
		return KEY_W'($urandom);
	endfunction

	function automatic void queue_item(input logic act, input logic [KEY_W-1:0] sc,
			input logic [KEY_W-1:0] tg, input bit drain);
		pending_t p;
		p.item.action = act;
		p.item.score  = sc;
		p.item.tag    = tg;
		p.drain_first = drain;
		pending_q.push_back(p);
	endfunction

	// Random run of items; pop_pct sets the share of pops
	function automatic void queue_random(input int n, input int pop_pct, input bit drain);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1, 100) <= pop_pct)
				queue_item(ACT_POP, KEY_W'($urandom), KEY_W'($urandom), drain && i == 0);
			else
				queue_item(ACT_INSERT, pick_score(), KEY_W'($urandom), drain && i == 0);
		end
	endfunction

	// Build the stimulus, release reset, then wait for the run to settle
	initial begin
		// directed: empty pop, extremes, ties at the top, drain to empty
		queue_item(ACT_POP, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_item(ACT_INSERT, 16'h0000, 16'h0000, 1'b0);
		queue_item(ACT_INSERT, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_item(ACT_INSERT, 16'hFFFF, 16'h0001, 1'b0);
		queue_item(ACT_INSERT, 16'h8000, 16'h1234, 1'b0);
		queue_item(ACT_INSERT, 16'h0005, 16'hAAAA, 1'b0);
		queue_item(ACT_INSERT, 16'h0005, 16'h5555, 1'b0);
		queue_item(ACT_INSERT, 16'h0000, 16'hFFFF, 1'b0);
		for (int i = 0; i < 8; i++)
			queue_item(ACT_POP, 16'h1234, 16'h4321, 1'b0);
		// equal keys on the way down
		for (int i = 1; i <= 4; i++)
			queue_item(ACT_INSERT, 16'h0007, KEY_W'(i), 1'b0);
		for (int i = 0; i < 5; i++)
			queue_item(ACT_POP, 16'h0000, 16'h0000, 1'b0);
		// mixed, then fill past capacity, then empty past zero, then mixed
		queue_random(300, 40, 1'b0);
		queue_random(560, 3, 1'b1);
		queue_random(560, 97, 1'b1);
		queue_random(220, 50, 1'b1);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || req_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Run: %0d items (%0d inserts, %0d pops), %0d replies checked.",
			items_taken, n_insert, n_pop, replies_seen);
		$display("Heap peaked at %0d entries; %0d full refusals, %0d empty refusals.",
			heap_peak, n_full, n_empty);
		if (fail_count == 0 && replies_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Time limit far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("Timeout at %0t with %0d replies outstanding", $time, replies_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Check replies against the oldest expectation, then record accepted items
	always @(posedge clk) begin : scoreboard
		out_item_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				replies_seen++;
				if (replies_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected reply, expected none, actual %0h", $time, rsp);
				end else begin
					want = replies_due.pop_front();
					check_field("popped_score", want.popped_score, rsp.popped_score);
					check_field("popped_tag", want.popped_tag, rsp.popped_tag);
					check_field("top_score", want.top_score, rsp.top_score);
					check_field("top_tag", want.top_tag, rsp.top_tag);
					check_field("count", want.count, rsp.count);
					check_field("status", want.status, rsp.status);
				end
			end
			if (req_valid && !req_stall) begin
				replies_due.push_back(heap_apply(req));
				items_taken++;
			end
			req_taken <= req_valid && !req_stall;
		end
	end

	// Offer items in bursts with random gaps; hold marked items until all replies are in
	always @(negedge clk) begin : item_driver
		logic     nxt_valid;
		in_item_t nxt_item;
		pending_t head;
		nxt_valid = req_valid;
		nxt_item  = req;
		if (arst_n) begin
			if (req_valid && req_taken) begin
				nxt_valid = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() != 0 &&
						!(pending_q[0].drain_first && replies_due.size() != 0)) begin
					head = pending_q.pop_front();
					nxt_valid = 1'b1;
					nxt_item  = head.item;
				end
			end
		end
		req_valid <= nxt_valid;
		req       <= nxt_item;
	end

	// Stall replies: one long hold-off, otherwise a changing pattern
	always @(negedge clk) begin : reply_staller
		logic nxt_stall;
		nxt_stall = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				nxt_stall = 1'b1;
			end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				nxt_stall = 1'b1;
			end else begin
				if (style_left <= 0) begin
					rx_style   = rx_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(32, 256);
				end
				style_left--;
				comb_phase++;
				case (rx_style)
					RX_OPEN:  nxt_stall = 1'b0;
					RX_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
					RX_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
					default:  nxt_stall = (comb_phase % 5) < 2;
				endcase
			end
		end
		rsp_stall <= nxt_stall;
	end

endmodule

// ===== sim.f =====
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/bmhq_ctrl.sv
design/binary_max_heap_queue_top.sv
tb/tb_binary_max_heap_queue_top.sv
